// ===== rtl/tpe_pkg.sv =====
`timescale 1ns / 1ps
package tpe_pkg;

   localparam int HashBitsDef  = 8;
   localparam int CacheEntries = 64;
   localparam int SlotWidth    = 6;
   localparam int MaxBytes     = 7;

   localparam logic [31:0] HashMul    = 32'd2654435761;
   localparam logic [31:0] ResetPixel = 32'hFF000000;

   localparam logic [7:0] OpRunS  = 8'h07;
   localparam logic [7:0] OpRunL  = 8'hD7;
   localparam logic [7:0] OpBgra2 = 8'hDF;
   localparam logic [7:0] OpBgra4 = 8'hE7;
   localparam logic [7:0] OpBgra8 = 8'hEF;
   localparam logic [7:0] OpA8    = 8'hF7;
   localparam logic [7:0] OpBgr8  = 8'hFF;

   typedef struct packed {
      logic [31:0] pixel;
      logic        last_pixel;
   } req_item_type;

   typedef struct packed {
      logic [7:0] op_byte;
      logic       last_of_item;
      logic       tile_end;
   } rsp_beat_type;

   typedef struct packed {
      logic [2:0]                        count;
      rsp_beat_type [MaxBytes-1:0]       beat;
   } rsp_burst_type;

   // up to four bytes, first byte in bits 7:0
   typedef struct packed {
      logic [2:0]  count;
      logic [31:0] bytes;
   } op_type;

   // one-hot highest bit of the zigzag code, zero for a zero delta
   function automatic logic [7:0] size_class(input logic [7:0] b);
      logic [7:0] m;
      logic [7:0] r;
      m = {b[6:0], 1'b0} ^ {8{b[7]}};
      r = 8'h01;
      for (int i = 1; i < 8; i++) begin
         if (m[i]) r = 8'(1 << i);
      end
      if (b == 8'h00) r = 8'h00;
      return r;
   endfunction

   function automatic op_type run_op(input logic [8:0] c);
      op_type o;
      logic [8:0] cm;
      cm = c - 9'd1;
      o = '0;
      if (c == 9'd0) begin
         o.count = 3'd0;
      end else if (c <= 9'd26) begin
         o.count = 3'd1;
         o.bytes[7:0] = OpRunS | {cm[4:0], 3'b000};
      end else begin
         o.count = 3'd2;
         o.bytes[7:0]  = OpRunL;
         o.bytes[15:8] = cm[7:0];
      end
      return o;
   endfunction

   function automatic op_type delta_op(input logic [31:0] cur, input logic [31:0] prev);
      op_type o;
      logic [7:0] d0, d1, d2, d3, d01, d21, c1, cls;
      logic [7:0] t0, t1, t2;
      logic [23:0] w;
      d0 = cur[7:0] - prev[7:0];
      d1 = cur[15:8] - prev[15:8];
      d2 = cur[23:16] - prev[23:16];
      d3 = cur[31:24] - prev[31:24];
      d01 = d0 - d1;
      d21 = d2 - d1;
      o = '0;
      if (d3 == 8'h00) begin
         c1 = size_class(d1);
         cls = size_class(d0) | size_class(d2) | c1;
         if (cls < 8'h04) begin
            t0 = d0 + 8'd2;
            t1 = d1 + 8'd2;
            t2 = d2 + 8'd2;
            o.count = 3'd1;
            o.bytes[7:0] = {t2[1:0], t1[1:0], t0[1:0], 2'b01};
         end else if (((c1 >> 6) | (size_class(d01) >> 4) | (size_class(d21) >> 4))
                      == 8'h00) begin
            t1 = d1 + 8'h20;
            t0 = d01 + 8'd8;
            t2 = d21 + 8'd8;
            o.count = 3'd2;
            o.bytes[7:0]  = {t1[5:0], 2'b10};
            o.bytes[15:8] = {t2[3:0], t0[3:0]};
         end else if (cls < 8'h80) begin
            t0 = d0 + 8'h40;
            t1 = d1 + 8'h40;
            t2 = d2 + 8'h40;
            w = {t2[6:0], t1[6:0], t0[6:0], 3'b011};
            o.count = 3'd3;
            o.bytes[23:0] = w;
         end else begin
            o.count = 3'd4;
            o.bytes = {d2, d1, d0, OpBgr8};
         end
      end else if ((d0 | d1 | d2) == 8'h00) begin
         o.count = 3'd2;
         o.bytes[15:0] = {d3, OpA8};
      end else begin
         cls = size_class(d0) | size_class(d1) | size_class(d2) | size_class(d3);
         if (cls < 8'h04) begin
            t0 = d0 + 8'd2;
            t1 = d1 + 8'd2;
            t2 = d2 + 8'd2;
            w[7:0] = d3 + 8'd2;
            o.count = 3'd2;
            o.bytes[15:0] = {w[1:0], t2[1:0], t1[1:0], t0[1:0], OpBgra2};
         end else if (cls < 8'h10) begin
            t0 = d0 + 8'd8;
            t1 = d1 + 8'd8;
            t2 = d2 + 8'd8;
            w[7:0] = d3 + 8'd8;
            o.count = 3'd3;
            o.bytes[23:0] = {w[3:0], t2[3:0], t1[3:0], t0[3:0], OpBgra4};
         end else begin
            o.count = 3'd4;
            o.bytes = {d2, d1, d0, OpBgra8};
            // fifth byte carried separately by the caller
         end
      end
      return o;
   endfunction

endpackage

// ===== rtl/tile_pixel_op_encoder_core.sv =====
`timescale 1ns / 1ps
// Lossless pixel-op encoder over 32-bit BGRA pixels, one tile at a time. Pixels go in
// through a two-entry queue that also forms the cache hash; the coding engine then
// takes one pixel at a time through a slot-table read, a colour-cache read and a code
// and update step, which waits for room, and drops all bytes for that pixel into a
// 16-entry byte queue, which drains one byte per cycle on the result side while it is
// popped. State goes back to its reset values right after the last pixel of a tile,
// with no clearing pass.
module tile_pixel_op_encoder_core #(
   parameter int HASH_BITS = tpe_pkg::HashBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_pixel,
   input  logic        req_last_pixel,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_op_byte,
   output logic        rsp_last_of_item,
   output logic        rsp_tile_end
);
   import tpe_pkg::*;

   logic                 head_valid, head_pop, room;
   req_item_type         head_item;
   logic [HASH_BITS-1:0] head_hash;
   rsp_burst_type        burst;

   tpe_front #(.HASH_BITS(HASH_BITS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_pixel, .req_last_pixel,
      .head_valid, .head_item, .head_hash, .head_pop
   );

   tpe_back #(.HASH_BITS(HASH_BITS)) u_back (
      .clock, .reset, .head_valid, .head_item, .head_hash, .head_pop, .room, .burst
   );

   tpe_out_fifo u_out (
      .clock, .reset, .burst, .room, .rsp_empty, .rsp_pop,
      .rsp_op_byte, .rsp_last_of_item, .rsp_tile_end
   );

endmodule

// ===== rtl/tpe_front.sv =====
`timescale 1ns / 1ps
module tpe_front #(
   parameter int HASH_BITS = tpe_pkg::HashBitsDef
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [31:0]          req_pixel,
   input  logic                 req_last_pixel,
   output logic                 head_valid,
   output tpe_pkg::req_item_type head_item,
   output logic [HASH_BITS-1:0] head_hash,
   input  logic                 head_pop
);
   import tpe_pkg::*;

   req_item_type         item_ff [2];
   logic [HASH_BITS-1:0] hash_ff [2];
   logic                 wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]           count_ff, count_in;
   logic [31:0]          prod;
   logic                 accept, take;

   assign req_full   = count_ff == 2'd2;
   assign accept     = req_push && !req_full;
   assign head_valid = count_ff != 2'd0;
   assign take       = head_pop && head_valid;
   assign head_item  = item_ff[rd_ff];
   assign head_hash  = hash_ff[rd_ff];
   assign prod       = req_pixel * HashMul;

   always_comb begin
      wr_in    = wr_ff ^ accept;
      rd_in    = rd_ff ^ take;
      count_in = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff[wr_ff] <= '{pixel: req_pixel, last_pixel: req_last_pixel};
         hash_ff[wr_ff] <= prod[31 -: HASH_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/tpe_out_fifo.sv =====
`timescale 1ns / 1ps
module tpe_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  tpe_pkg::rsp_burst_type burst,
   output logic                  room,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_op_byte,
   output logic                  rsp_last_of_item,
   output logic                  rsp_tile_end
);
   import tpe_pkg::*;

   localparam int Depth = 16;

   rsp_beat_type mem [Depth];
   logic [3:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [4:0]   count_ff, count_in;
   logic         take;
   rsp_beat_type head;

   assign rsp_empty        = count_ff == 5'd0;
   assign take             = rsp_pop && !rsp_empty;
   assign room             = count_ff <= 5'(Depth - MaxBytes);
   assign head             = mem[rd_ff];
   assign rsp_op_byte      = head.op_byte;
   assign rsp_last_of_item = head.last_of_item;
   assign rsp_tile_end     = head.tile_end;

   always_comb begin
      wr_in    = wr_ff + {1'b0, burst.count};
      rd_in    = rd_ff + {3'b000, take};
      count_in = count_ff + {2'b00, burst.count} - {4'b0000, take};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxBytes; i++) begin
         if (3'(i) < burst.count) mem[wr_ff + 4'(i)] <= burst.beat[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      burst.count != 3'd0 |-> room)
      else $error("byte queue pushed without room");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 5'(Depth))
      else $error("byte queue overflow");
`endif

endmodule

// ===== rtl/tpe_back.sv =====
`timescale 1ns / 1ps
module tpe_back #(
   parameter int HASH_BITS = tpe_pkg::HashBitsDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  tpe_pkg::req_item_type head_item,
   input  logic [HASH_BITS-1:0]  head_hash,
   output logic                  head_pop,
   input  logic                  room,
   output tpe_pkg::rsp_burst_type burst
);
   import tpe_pkg::*;

   localparam int Slots = 1 << HASH_BITS;

   typedef enum logic [1:0] {S_SLOT, S_CACHE, S_EXEC} state_type;

   state_type              state_ff;
   logic [SlotWidth-1:0]   slot_mem [Slots];
   logic [31:0]            cache_mem [CacheEntries];
   logic [Slots-1:0]       slot_vld_ff, slot_vld_in;
   logic [CacheEntries-1:0] cache_vld_ff, cache_vld_in;
   logic [SlotWidth-1:0]   slot_q_ff, cache_slot_ff, slot_sel;
   logic                   slot_qv_ff, cache_qv_ff;
   logic [31:0]            cache_q_ff, cache_pix;
   logic [31:0]            prev_ff, prev_in;
   logic [7:0]             repeat_ff, repeat_in;
   logic [SlotWidth-1:0]   next_ff, next_in;
   logic [31:0]            px;
   logic                   last, same, hit, miss, commit, wrap;
   logic [8:0]             r9;
   op_type                 run_o, op_o;
   logic [7:0]             extra_byte;
   logic [2:0]             n, j;
   logic [7:0]             kbyte;

   assign px        = head_item.pixel;
   assign last      = head_item.last_pixel;
   assign slot_sel  = slot_qv_ff ? slot_q_ff : '0;
   assign cache_pix = cache_qv_ff ? cache_q_ff : ResetPixel;
   assign same      = px == prev_ff;
   assign hit       = cache_pix == px;
   assign miss      = !same && !hit;
   assign commit    = state_ff == S_EXEC && head_valid && room;
   assign head_pop  = commit;
   assign r9        = {1'b0, repeat_ff} + 9'd1;
   assign wrap      = r9 == 9'd256;

   always_comb begin
      run_o = '0;
      op_o  = '0;
      extra_byte = px[31:24] - prev_ff[31:24];
      if (same) begin
         if (wrap) begin
            run_o.count = 3'd2;
            run_o.bytes[15:0] = {8'hFF, OpRunL};
         end else if (last) begin
            run_o = run_op(r9);
         end
      end else begin
         run_o = run_op({1'b0, repeat_ff});
         if (hit) begin
            op_o.count = 3'd1;
            op_o.bytes[7:0] = {cache_slot_ff, 2'b00};
         end else begin
            op_o = delta_op(px, prev_ff);
         end
      end
   end

   // full bgra8 is five bytes: the alpha delta follows the four in op_o
   always_comb begin
      logic five;
      five = miss && op_o.bytes[7:0] == OpBgra8 && op_o.count == 3'd4;
      n = run_o.count + op_o.count + {2'b00, five};
      burst = '0;
      for (int k = 0; k < MaxBytes; k++) begin
         j = 3'(k) - run_o.count;
         if (3'(k) < run_o.count) kbyte = run_o.bytes[8*(k%2) +: 8];
         else if (j < 3'd4) kbyte = op_o.bytes[8*j[1:0] +: 8];
         else kbyte = extra_byte;
         burst.beat[k].op_byte      = kbyte;
         burst.beat[k].last_of_item = 3'(k) == n - 3'd1;
         burst.beat[k].tile_end     = last && 3'(k) == n - 3'd1;
      end
      burst.count = commit ? n : 3'd0;
   end

   always_comb begin
      prev_in      = prev_ff;
      repeat_in    = repeat_ff;
      next_in      = next_ff;
      slot_vld_in  = slot_vld_ff;
      cache_vld_in = cache_vld_ff;
      if (commit) begin
         if (same) begin
            repeat_in = wrap ? 8'd0 : r9[7:0];
         end else begin
            repeat_in = 8'd0;
            prev_in   = px;
            if (miss) begin
               slot_vld_in[head_hash] = 1'b1;
               cache_vld_in[next_ff]  = 1'b1;
               next_in = next_ff + SlotWidth'(1);
            end
         end
         if (last) begin
            prev_in      = ResetPixel;
            repeat_in    = 8'd0;
            next_in      = '0;
            slot_vld_in  = '0;
            cache_vld_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SLOT) slot_q_ff <= slot_mem[head_hash];
      if (state_ff == S_CACHE) begin
         cache_q_ff    <= cache_mem[slot_sel];
         cache_slot_ff <= slot_sel;
      end
      if (commit && miss) begin
         slot_mem[head_hash] <= next_ff;
         cache_mem[next_ff]  <= px;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SLOT;
         prev_ff      <= ResetPixel;
         repeat_ff    <= '0;
         next_ff      <= '0;
         slot_vld_ff  <= '0;
         cache_vld_ff <= '0;
         slot_qv_ff   <= 1'b0;
         cache_qv_ff  <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         repeat_ff    <= repeat_in;
         next_ff      <= next_in;
         slot_vld_ff  <= slot_vld_in;
         cache_vld_ff <= cache_vld_in;
         case (state_ff)
            S_SLOT: begin
               if (head_valid) begin
                  slot_qv_ff <= slot_vld_ff[head_hash];
                  state_ff   <= S_CACHE;
               end
            end
            S_CACHE: begin
               cache_qv_ff <= cache_vld_ff[slot_sel];
               state_ff    <= S_EXEC;
            end
            S_EXEC: begin
               if (commit) state_ff <= S_SLOT;
            end
            default: state_ff <= S_SLOT;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_tile_reset: assert property (@(posedge clock) disable iff (reset)
      commit && last |=> next_ff == '0 && repeat_ff == 8'd0 && prev_ff == ResetPixel)
      else $error("state not cleared after tile end");
   a_prev_update: assert property (@(posedge clock) disable iff (reset)
      commit && !same && !last |=> prev_ff == $past(px))
      else $error("previous pixel not updated");
   a_pop_exec: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> state_ff == S_EXEC && room)
      else $error("item retired outside execute");
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      commit && last |-> burst.count != 3'd0)
      else $error("tile end produced no byte");
`endif

endmodule

// ===== tb/sv/tb_tile_pixel_op_encoder_core.sv =====
`timescale 1ns / 1ps
module tb_tile_pixel_op_encoder_core;
   import tpe_pkg::*;

   // predicts the op byte stream of each tile and checks bytes in order
   class op_stream_board;
      logic [31:0]  prev_px;
      int unsigned  run_len;
      logic [31:0]  colours[CacheEntries];
      logic [5:0]   slots[256];
      logic [5:0]   next_slot;
      logic [7:0]   pend[$];
      rsp_beat_type expected[$];
      int           mismatches;
      int           bytes_seen;
      int           tiles_done;

      function new();
         mismatches = 0;
         bytes_seen = 0;
         tiles_done = 0;
         clear();
      endfunction

      function void clear();
         prev_px = ResetPixel;
         run_len = 0;
         next_slot = '0;
         foreach (colours[i]) colours[i] = ResetPixel;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function logic [7:0] zz_class(logic [7:0] b);
         logic [7:0] m;
         int         r;
         m = {b[6:0], 1'b0} ^ {8{b[7]}};
         r = 0;
         while (m > 1) begin
            m = m >> 1;
            r++;
         end
         return (b == 0) ? 8'h00 : 8'(1 << r);
      endfunction

      function void flush_run();
         logic [7:0] n;
         if (run_len > 0) begin
            n = 8'(run_len - 1);
            if (run_len <= 26) pend.push_back(OpRunS | {n[4:0], 3'b000});
            else begin
               pend.push_back(OpRunL);
               pend.push_back(n);
            end
            run_len = 0;
         end
      endfunction

      function void code_delta(logic [31:0] cur, logic [31:0] prev);
         logic [7:0]  d0, d1, d2, d3, d01, d21, c1, cls, t0, t1, t2, t3;
         logic [23:0] w;
         d0 = cur[7:0] - prev[7:0];
         d1 = cur[15:8] - prev[15:8];
         d2 = cur[23:16] - prev[23:16];
         d3 = cur[31:24] - prev[31:24];
         d01 = d0 - d1;
         d21 = d2 - d1;
         if (d3 == 0) begin
            c1 = zz_class(d1);
            cls = zz_class(d0) | zz_class(d2) | c1;
            if (cls < 8'h04) begin
               t0 = d0 + 8'd2; t1 = d1 + 8'd2; t2 = d2 + 8'd2;
               pend.push_back({t2[1:0], t1[1:0], t0[1:0], 2'b01});
            end else if (((c1 >> 6) | (zz_class(d01) >> 4) | (zz_class(d21) >> 4)) == 0) begin
               t1 = d1 + 8'h20; t0 = d01 + 8'd8; t2 = d21 + 8'd8;
               pend.push_back({t1[5:0], 2'b10});
               pend.push_back({t2[3:0], t0[3:0]});
            end else if (cls < 8'h80) begin
               t0 = d0 + 8'h40; t1 = d1 + 8'h40; t2 = d2 + 8'h40;
               w = {t2[6:0], t1[6:0], t0[6:0], 3'b011};
               pend.push_back(w[7:0]);
               pend.push_back(w[15:8]);
               pend.push_back(w[23:16]);
            end else begin
               pend.push_back(OpBgr8);
               pend.push_back(d0);
               pend.push_back(d1);
               pend.push_back(d2);
            end
         end else if ((d0 | d1 | d2) == 0) begin
            pend.push_back(OpA8);
            pend.push_back(d3);
         end else begin
            cls = zz_class(d0) | zz_class(d1) | zz_class(d2) | zz_class(d3);
            if (cls < 8'h04) begin
               t0 = d0 + 8'd2; t1 = d1 + 8'd2; t2 = d2 + 8'd2; t3 = d3 + 8'd2;
               pend.push_back(OpBgra2);
               pend.push_back({t3[1:0], t2[1:0], t1[1:0], t0[1:0]});
            end else if (cls < 8'h10) begin
               t0 = d0 + 8'd8; t1 = d1 + 8'd8; t2 = d2 + 8'd8; t3 = d3 + 8'd8;
               pend.push_back(OpBgra4);
               pend.push_back({t1[3:0], t0[3:0]});
               pend.push_back({t3[3:0], t2[3:0]});
            end else begin
               pend.push_back(OpBgra8);
               pend.push_back(d0);
               pend.push_back(d1);
               pend.push_back(d2);
               pend.push_back(d3);
            end
         end
      endfunction

      function void note_pixel(logic [31:0] px, logic last);
         logic [31:0]  h;
         logic [5:0]   s;
         rsp_beat_type b;
         pend.delete();
         if (px == prev_px) begin
            run_len++;
            if (run_len == 256) begin
               pend.push_back(OpRunL);
               pend.push_back(8'hFF);
               run_len = 0;
            end
         end else begin
            flush_run();
            h = px * HashMul;
            s = slots[h[31:24]];
            if (colours[s] == px) begin
               pend.push_back({s, 2'b00});
            end else begin
               slots[h[31:24]] = next_slot;
               colours[next_slot] = px;
               next_slot = next_slot + 6'd1;
               code_delta(px, prev_px);
            end
            prev_px = px;
         end
         if (last) flush_run();
         foreach (pend[k]) begin
            b.op_byte = pend[k];
            b.last_of_item = (k == pend.size() - 1);
            b.tile_end = b.last_of_item && last;
            expected.push_back(b);
         end
         if (last) begin
            clear();
            tiles_done++;
         end
      endfunction

      function void check_byte(logic [7:0] op, logic loi, logic te);
         rsp_beat_type e;
         bytes_seen++;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %02h last_of_item %0b tile_end %0b", op, loi, te);
            return;
         end
         e = expected.pop_front();
         if (e.op_byte !== op || e.last_of_item !== loi || e.tile_end !== te) begin
            mismatches++;
            if (mismatches <= 10)
               $display("byte %0d: expected %02h/%0b/%0b got %02h/%0b/%0b", bytes_seen,
                        e.op_byte, e.last_of_item, e.tile_end, op, loi, te);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_pixel = '0;
   logic        req_last_pixel = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_op_byte;
   logic        rsp_last_of_item;
   logic        rsp_tile_end;

   op_stream_board board = new();
   req_item_type   pixels[$];
   bit             quiet = 1'b0;

   tile_pixel_op_encoder_core u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_pixel(req_pixel), .req_last_pixel(req_last_pixel),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_op_byte(rsp_op_byte), .rsp_last_of_item(rsp_last_of_item),
      .rsp_tile_end(rsp_tile_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] nudge(logic [7:0] v);
      case ($urandom_range(0, 6))
         0: return v;
         1: return v + 8'($urandom_range(0, 3)) - 8'd2;
         2: return v + 8'($urandom_range(0, 15)) - 8'd8;
         3: return v + 8'($urandom_range(0, 63)) - 8'd32;
         4: return v + 8'($urandom_range(0, 127)) - 8'd64;
         5: return v ^ 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic add_pixel(logic [31:0] px, logic last);
      req_item_type it;
      it.pixel = px;
      it.last_pixel = last;
      pixels.push_back(it);
   endtask

   task automatic build_stimulus();
      logic [31:0] px, recent[$];
      int          len, tile;
      // directed: run from the reset pixel, several op kinds, cache hit, run lengths
      add_pixel(32'hFF000000, 1'b0);
      add_pixel(32'hFF000000, 1'b0);
      add_pixel(32'hFF010201, 1'b0);
      add_pixel(32'hFF0A1408, 1'b0);
      add_pixel(32'hFF4A3468, 1'b0);
      add_pixel(32'hFF00FF80, 1'b0);
      add_pixel(32'h00FF0000, 1'b0);
      add_pixel(32'hFF000000, 1'b0);
      add_pixel(32'hFE010000, 1'b0);
      add_pixel(32'hFA050308, 1'b0);
      add_pixel(32'h12345678, 1'b0);
      add_pixel(32'h12345678, 1'b0);
      add_pixel(32'hFFFFFFFF, 1'b0);
      add_pixel(32'h12345678, 1'b0);
      repeat (27) add_pixel(32'h12345678, 1'b0);
      add_pixel(32'h00000000, 1'b1);
      add_pixel(32'hFF000000, 1'b1);
      add_pixel(32'h80808080, 1'b1);
      // random tiles; tile 3, if it has at least three pixels, carries a run around the 256 boundary
      tile = 0;
      while (pixels.size() < 455) begin
         px = ResetPixel;
         recent.delete();
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 110) : $urandom_range(1, 30);
         for (int i = 0; i < len; i++) begin
            if (tile == 3 && i == 2) begin
               repeat (255 + $urandom_range(0, 2)) add_pixel(px, 1'b0);
            end
            case ($urandom_range(0, 9))
               0, 1, 2: ;
               3, 4: if (recent.size() > 0) px = recent[$urandom_range(0, recent.size() - 1)];
               5, 6, 7: px = {($urandom_range(0, 2) == 0) ? nudge(px[31:24]) : px[31:24],
                              nudge(px[23:16]), nudge(px[15:8]), nudge(px[7:0])};
               default: px = $urandom;
            endcase
            recent.push_back(px);
            if (recent.size() > 80) void'(recent.pop_front());
            add_pixel(px, i == len - 1);
         end
         tile++;
      end
   endtask

   initial begin
      int n;
      build_stimulus();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (pixels[i]) begin
         if (i > pixels.size() * 85 / 100) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            req_push <= 1'b0;
            repeat (n) @(posedge clock);
         end
         req_push <= 1'b1;
         req_pixel <= pixels[i].pixel;
         req_last_pixel <= pixels[i].last_pixel;
         do @(posedge clock); while (req_full);
         board.note_pixel(pixels[i].pixel, pixels[i].last_pixel);
      end
      req_push <= 1'b0;
      while (board.expected.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d pixels in %0d tiles, checked %0d op bytes",
               pixels.size(), board.tiles_done, board.bytes_seen);
      if (board.mismatches == 0 && board.expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // result side: random stall bursts, none once quiet
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            board.check_byte(rsp_op_byte, rsp_last_of_item, rsp_tile_end);
         if (stall == 0 && !quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 16);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
